@@ src/lru_slot_manager_idle_evict_macros.svh @@
// Assertion macros shared by the slot manager RTL.
`ifndef LRU_SLOT_MANAGER_IDLE_EVICT_MACROS_SVH
`define LRU_SLOT_MANAGER_IDLE_EVICT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/lsm_pkg.sv @@
// Types, codes and defaults of the LRU slot manager.
package lsm_pkg;

  localparam int SLOTS_DEF        = 64;
  localparam int CONN_ID_BITS_DEF = 16;

  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd60;

  // Configuration port: byte address bits and register word indexes.
  localparam int          CFG_AW           = 3;
  localparam logic [0:0]  REG_IDLE_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_TOUCH   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ALLOC_FREE  = 3'd0,
    ST_ALLOC_EVICT = 3'd1,
    ST_REJECT      = 3'd2,
    ST_DONE        = 3'd3,
    ST_BAD_SLOT    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UNL_P,
    S_PUSH_A,
    S_PUSH_B,
    S_FREE,
    S_RESULT
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  slot;
    logic [15:0] conn_id;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  granted;
    logic [15:0] evicted;
  } res_t;

endpackage

@@ src/lsm_cfg.sv @@
// APB register block holding the idle timeout.
module lsm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsm_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 idle_timeout
);

  logic [31:0] timeout_r;
  logic [31:0] timeout_nxt;
  logic [0:0]  widx;

  assign widx   = paddr[lsm_pkg::CFG_AW-1 -: 1];
  assign pready = 1'b1;

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && pready && widx == lsm_pkg::REG_IDLE_TIMEOUT) begin
      timeout_nxt = pwdata;
    end
  end

  always_comb begin
    case (widx)
      lsm_pkg::REG_IDLE_TIMEOUT: prdata = timeout_r;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= lsm_pkg::IDLE_TIMEOUT_RST;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign idle_timeout = timeout_r;

endmodule

@@ src/lsm_engine.sv @@
// Request sequencer with the link and slot-data memories.
module lsm_engine #(
  parameter int SLOTS        = lsm_pkg::SLOTS_DEF,
  parameter int CONN_ID_BITS = lsm_pkg::CONN_ID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsm_pkg::req_t req,
  input  logic [31:0]   idle_timeout,
  output logic          res_valid,
  input  logic          res_take,
  output lsm_pkg::res_t res
);

  localparam int NW = $clog2(SLOTS + 3);
  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);
  localparam int CW = CONN_ID_BITS;

  localparam logic [NW-1:0] N_HEAD = NW'(SLOTS);
  localparam logic [NW-1:0] N_TAIL = NW'(SLOTS + 1);
  localparam logic [NW-1:0] N_NONE = NW'(SLOTS + 2);
  localparam logic [NW-1:0] N_LAST = NW'(SLOTS - 1);
  localparam logic [31:0]   SLOTS_U = 32'(SLOTS);

  // Link word: prev in the upper half, next in the lower half.
  logic [2*NW-1:0] link_mem [SLOTS];
  logic [CW+31:0]  data_mem [SLOTS];
  logic [2*NW-1:0] link_rd_r;
  logic [CW+31:0]  data_rd_r;

  lsm_pkg::eng_state_t state_r, state_nxt;
  logic [NW-1:0] head_next_r, head_next_nxt;
  logic [NW-1:0] tail_prev_r, tail_prev_nxt;
  logic [NW-1:0] free_head_r, free_head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [NW-1:0] p_r, p_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic          push_r, push_nxt;
  lsm_pkg::res_t res_r, res_nxt;

  logic [1:0]    cmd_r;
  logic [NW-1:0] addr_r;
  logic [CW-1:0] conn_r;
  logic [31:0]   now_r;
  logic          oob_r;

  logic          accept;
  logic [NW-1:0] acc_addr;
  logic [SW-1:0] rd_addr;

  logic          lk_we_nxt, lk_we_prv;
  logic [SW-1:0] lk_waddr;
  logic [NW-1:0] lk_wnxt, lk_wprv;
  logic          dt_we_conn, dt_we_seen;

  logic          fresh;
  logic [NW-1:0] fresh_next, rd_nxt, rd_prv;
  logic [31:0]   age;
  logic          evictable, free_ok, lru_ok, slot_bad, do_unlink;

  // Pick the node to look at as the request is taken.
  always_comb begin
    case (req.cmd)
      lsm_pkg::CMD_ALLOC:   acc_addr = (free_head_r < N_HEAD) ? free_head_r : tail_prev_r;
      lsm_pkg::CMD_TOUCH,
      lsm_pkg::CMD_RELEASE: acc_addr = NW'(req.slot);
      default:              acc_addr = free_head_r;
    endcase
  end
  assign rd_addr = SW'(acc_addr);

  // Entries at or above the fill count were never written; their links follow from the index.
  assign fresh      = addr_r >= NW'(fill_r);
  assign fresh_next = (addr_r == N_LAST) ? N_NONE : addr_r + 1'b1;
  assign rd_nxt     = fresh ? fresh_next : link_rd_r[NW-1:0];
  assign rd_prv     = fresh ? N_NONE : link_rd_r[2*NW-1:NW];
  assign age        = now_r - data_rd_r[31:0];
  assign evictable  = age > idle_timeout;
  assign free_ok    = free_head_r < N_HEAD;
  assign lru_ok     = tail_prev_r != N_HEAD;
  assign slot_bad   = oob_r || fresh || rd_prv == N_NONE;

  always_comb begin
    state_nxt     = state_r;
    head_next_nxt = head_next_r;
    tail_prev_nxt = tail_prev_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    push_nxt      = push_r;
    res_nxt       = res_r;
    lk_we_nxt     = 1'b0;
    lk_we_prv     = 1'b0;
    lk_waddr      = SW'(addr_r);
    lk_wnxt       = '0;
    lk_wprv       = '0;
    dt_we_conn    = 1'b0;
    dt_we_seen    = 1'b0;
    do_unlink     = 1'b0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    accept        = 1'b0;

    case (state_r)
      lsm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept    = 1'b1;
          state_nxt = lsm_pkg::S_READ;
        end
      end

      lsm_pkg::S_READ: begin
        res_nxt.status  = lsm_pkg::ST_REJECT;
        res_nxt.granted = '0;
        res_nxt.evicted = '0;
        state_nxt       = lsm_pkg::S_RESULT;
        case (cmd_r)
          lsm_pkg::CMD_ALLOC: begin
            if (free_ok) begin
              // Pop the free list and write the new node's links right away.
              lk_we_nxt     = 1'b1;
              lk_we_prv     = 1'b1;
              lk_wnxt       = head_next_r;
              lk_wprv       = N_HEAD;
              free_head_nxt = rd_nxt;
              if (fresh) begin
                fill_nxt = fill_r + 1'b1;
              end
              dt_we_conn      = 1'b1;
              dt_we_seen      = 1'b1;
              res_nxt.status  = lsm_pkg::ST_ALLOC_FREE;
              res_nxt.granted = 6'(addr_r);
              state_nxt       = lsm_pkg::S_PUSH_B;
            end else if (lru_ok && evictable) begin
              do_unlink       = 1'b1;
              push_nxt        = 1'b1;
              dt_we_conn      = 1'b1;
              dt_we_seen      = 1'b1;
              res_nxt.status  = lsm_pkg::ST_ALLOC_EVICT;
              res_nxt.granted = 6'(addr_r);
              res_nxt.evicted = 16'(data_rd_r[CW+31:32]);
              state_nxt       = lsm_pkg::S_UNL_P;
            end
          end
          lsm_pkg::CMD_TOUCH,
          lsm_pkg::CMD_RELEASE: begin
            if (slot_bad) begin
              res_nxt.status = lsm_pkg::ST_BAD_SLOT;
            end else begin
              do_unlink      = 1'b1;
              push_nxt       = (cmd_r == lsm_pkg::CMD_TOUCH);
              dt_we_seen     = (cmd_r == lsm_pkg::CMD_TOUCH);
              res_nxt.status = lsm_pkg::ST_DONE;
              state_nxt      = lsm_pkg::S_UNL_P;
            end
          end
          default: begin
            state_nxt = lsm_pkg::S_RESULT;
          end
        endcase
        // First half of the unlink: next of the predecessor.
        if (do_unlink) begin
          p_nxt = rd_prv;
          q_nxt = rd_nxt;
          if (rd_prv == N_HEAD) begin
            head_next_nxt = rd_nxt;
          end else begin
            lk_we_nxt = 1'b1;
            lk_waddr  = SW'(rd_prv);
            lk_wnxt   = rd_nxt;
          end
        end
      end

      lsm_pkg::S_UNL_P: begin
        if (q_r == N_TAIL) begin
          tail_prev_nxt = p_r;
        end else begin
          lk_we_prv = 1'b1;
          lk_waddr  = SW'(q_r);
          lk_wprv   = p_r;
        end
        state_nxt = push_r ? lsm_pkg::S_PUSH_A : lsm_pkg::S_FREE;
      end

      lsm_pkg::S_PUSH_A: begin
        lk_we_nxt = 1'b1;
        lk_we_prv = 1'b1;
        lk_wnxt   = head_next_r;
        lk_wprv   = N_HEAD;
        state_nxt = lsm_pkg::S_PUSH_B;
      end

      lsm_pkg::S_PUSH_B: begin
        // Old first node points back to the new one; head advances.
        if (head_next_r == N_TAIL) begin
          tail_prev_nxt = addr_r;
        end else begin
          lk_we_prv = 1'b1;
          lk_waddr  = SW'(head_next_r);
          lk_wprv   = addr_r;
        end
        head_next_nxt = addr_r;
        state_nxt     = lsm_pkg::S_RESULT;
      end

      lsm_pkg::S_FREE: begin
        lk_we_nxt     = 1'b1;
        lk_we_prv     = 1'b1;
        lk_wnxt       = free_head_r;
        lk_wprv       = N_NONE;
        free_head_nxt = addr_r;
        state_nxt     = lsm_pkg::S_RESULT;
      end

      lsm_pkg::S_RESULT: begin
        res_valid = 1'b1;
        if (res_take) begin
          in_ready = 1'b1;
          if (in_valid) begin
            accept    = 1'b1;
            state_nxt = lsm_pkg::S_READ;
          end else begin
            state_nxt = lsm_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = lsm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsm_pkg::S_IDLE;
      head_next_r <= N_TAIL;
      tail_prev_r <= N_HEAD;
      free_head_r <= '0;
      fill_r      <= '0;
      push_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_next_r <= head_next_nxt;
      tail_prev_r <= tail_prev_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      push_r      <= push_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
    if (accept) begin
      cmd_r  <= req.cmd;
      addr_r <= acc_addr;
      conn_r <= CW'(req.conn_id);
      now_r  <= req.now;
      oob_r  <= 32'(req.slot) >= SLOTS_U;
    end
  end

  // Link memory: one write port with field enables, one registered read.
  always_ff @(posedge clk) begin
    if (lk_we_nxt) begin
      link_mem[lk_waddr][NW-1:0] <= lk_wnxt;
    end
    if (lk_we_prv) begin
      link_mem[lk_waddr][2*NW-1:NW] <= lk_wprv;
    end
    if (accept) begin
      link_rd_r <= link_mem[rd_addr];
    end
  end

  // Slot data memory: connection id above the last-seen stamp.
  always_ff @(posedge clk) begin
    if (dt_we_conn) begin
      data_mem[SW'(addr_r)][CW+31:32] <= conn_r;
    end
    if (dt_we_seen) begin
      data_mem[SW'(addr_r)][31:0] <= now_r;
    end
    if (accept) begin
      data_rd_r <= data_mem[rd_addr];
    end
  end

  assign res = res_r;

endmodule

@@ src/lru_slot_manager_idle_evict.sv @@
// Top level of the LRU connection-slot manager with idle eviction.
//
//  port group | dir | payload
//  -----------+-----+--------------------------------------------------------
//  in_*       | in  | tuser: command; tdata: slot, conn_id, now
//  out_*      | out | tuser: status; tdata: granted_slot, evicted_conn
//  cfg_*      | in  | APB, reg 0 at 0x0: idle_timeout (reset 60)
//
// A request runs S_READ, then S_PUSH_B to allocate from the free list, S_UNL_P
// and S_FREE to release, S_UNL_P, S_PUSH_A, S_PUSH_B to touch or evict, none
// for reject or bad slot, then S_RESULT, as the single link write port takes
// one link update per cycle. Reset is synchronous; the block takes requests
// right after it, since a fill count stands in for the initial free chain. A
// result waits in the output register while the next request is taken.
`include "lru_slot_manager_idle_evict_macros.svh"

module lru_slot_manager_idle_evict #(
  parameter int SLOTS        = lsm_pkg::SLOTS_DEF,
  parameter int CONN_ID_BITS = lsm_pkg::CONN_ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [55:0]                 in_tdata,   // slot[5:0], conn_id[21:6], now[53:22]
  input  logic [1:0]                  in_tuser,   // command[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // granted_slot[5:0], evicted_conn[21:6]
  output logic [2:0]                  out_tuser,  // status[2:0]
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lsm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [31:0]   idle_timeout;
  lsm_pkg::req_t req;
  lsm_pkg::res_t res;
  logic          res_valid;
  logic          res_take;
  logic          out_valid_r, out_valid_nxt;
  lsm_pkg::res_t out_res_r;

  lsm_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .idle_timeout (idle_timeout)
  );

  assign req.cmd     = in_tuser;
  assign req.slot    = in_tdata[5:0];
  assign req.conn_id = in_tdata[21:6];
  assign req.now     = in_tdata[53:22];

  lsm_engine #(
    .SLOTS        (SLOTS),
    .CONN_ID_BITS (CONN_ID_BITS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req          (req),
    .idle_timeout (idle_timeout),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // Move a finished result into the output register once it is free.
  assign res_take      = res_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {2'b00, out_res_r.evicted, out_res_r.granted};

  `LSM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "request accepted with no cycle of work")
  `LSM_ASSERT_IMP(a_evict_only_conn, clk, rst_n, out_valid_r && out_res_r.status != lsm_pkg::ST_ALLOC_EVICT, out_res_r.evicted == '0, "evicted id on a result that evicted nothing")
  `LSM_ASSERT_IMP(a_grant_only_alloc, clk, rst_n, out_valid_r && out_res_r.status != lsm_pkg::ST_ALLOC_FREE && out_res_r.status != lsm_pkg::ST_ALLOC_EVICT, out_res_r.granted == '0, "granted slot on a result that granted nothing")
  `LSM_ASSERT_NXT(a_out_drains, clk, rst_n, out_valid_r && out_tready && !res_take, !out_valid_r, "output register kept a result already taken")

endmodule
